// ===== rtl/lspd_pkg.sv =====
// ----------------------------------------------------------------------------
// lspd_pkg: shared types and constants for the LSB stego payload decoder
// Phase codes, result kinds, error codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package lspd_pkg;

  // Decode phase, one-hot
  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_MAGIC   = 8'b0000_0010,
    PH_EXTLEN  = 8'b0000_0100,
    PH_EXTCHR  = 8'b0000_1000,
    PH_PAYLEN  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_HALT    = 8'b1000_0000
  } phase_t;

  // Result kinds
  localparam logic [2:0] KIND_EXTLEN  = 3'd0;
  localparam logic [2:0] KIND_EXTCHR  = 3'd1;
  localparam logic [2:0] KIND_PAYLEN  = 3'd2;
  localparam logic [2:0] KIND_PAYBYTE = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Error codes
  localparam logic ERR_MAGIC   = 1'b0;
  localparam logic ERR_EXT_LEN = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAGIC_CHARS     = 2'd0,
    REG_MAGIC_COUNT     = 2'd1,
    REG_HEADER_BYTES    = 2'd2,
    REG_EXTENSION_LIMIT = 2'd3
  } reg_idx_t;

  // Register reset values
  localparam logic [63:0] MAGIC_CHARS_RST     = 64'd8998;
  localparam logic [3:0]  MAGIC_COUNT_RST     = 4'd2;
  localparam logic [7:0]  HEADER_BYTES_RST    = 8'd54;
  localparam logic [7:0]  EXTENSION_LIMIT_RST = 8'd8;

  localparam logic [3:0]  MAGIC_MAX = 4'd8;
  localparam logic [4:0]  LAST_BIT_CHAR = 5'd7;
  localparam logic [4:0]  LAST_BIT_SIZE = 5'd31;

  // Result beat as held in the output register
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last_byte;
    logic        error_code;
  } result_t;

endpackage

// ===== rtl/lsb_stego_payload_decoder.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_payload_decoder: LSB steganography decoder for BMP byte streams
// Skips the file header, gathers image-byte LSBs MSB first, checks the magic
// string and emits extension length, extension chars, payload length and
// payload bytes, or an error beat that halts decoding until restart.
// ----------------------------------------------------------------------------
// Result timing: a result appears in the output register in the cycle after the input
//   beat that completes it is accepted.
// Throughput: one input beat per cycle while the input is not stalled; the whole decode
//   step is one shift, a few compares and a decrement ahead of the state and output registers.
// Input stalls only while a result sits in the output register and the sink stalls.
// Reset (rst_n low, synchronous): clear decode state and output valid, load
//   register reset values (magic 8998, count 2, header 54, limit 8).
// ----------------------------------------------------------------------------
module lsb_stego_payload_decoder
  import lspd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_byte,
  input  logic        in_restart,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_value,
  output logic        out_last_byte,
  output logic        out_error_code
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [63:0] magic_chars_r;
  logic [3:0]  magic_count_r;
  logic [7:0]  header_bytes_r;
  logic [7:0]  extension_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_chars_r     <= MAGIC_CHARS_RST;
      magic_count_r     <= MAGIC_COUNT_RST;
      header_bytes_r    <= HEADER_BYTES_RST;
      extension_limit_r <= EXTENSION_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAGIC_CHARS:     magic_chars_r     <= cfg_data;
        REG_MAGIC_COUNT:     magic_count_r     <= cfg_data[3:0];
        REG_HEADER_BYTES:    header_bytes_r    <= cfg_data[7:0];
        REG_EXTENSION_LIMIT: extension_limit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Decode state
  // --------------------------------------------------------------------------
  phase_t      phase_r,        phase_nxt;
  logic [7:0]  header_count_r, header_count_nxt;
  logic [4:0]  bit_count_r,    bit_count_nxt;
  logic [31:0] shift_word_r,   shift_word_nxt;
  logic [7:0]  item_count_r,   item_count_nxt;
  logic [7:0]  ext_length_r,   ext_length_nxt;
  logic [31:0] payload_left_r, payload_left_nxt;

  // output register (skid stage between the two sides)
  logic        out_valid_r;
  result_t     out_r;

  logic        in_acc;
  logic        out_acc;
  logic        res_vld;
  result_t     res;

  // Hold the input only while a finished beat waits on a stalled sink.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign out_acc  = out_valid_r & ~out_stall;

  // Magic characters actually checked: counts above eight act as eight.
  logic [3:0] magic_used;
  assign magic_used = (magic_count_r > MAGIC_MAX) ? MAGIC_MAX : magic_count_r;

  // --------------------------------------------------------------------------
  // One decode step for the accepted beat
  // --------------------------------------------------------------------------
  always_comb begin
    phase_t      ph;
    logic [7:0]  hc;
    logic [4:0]  bc;
    logic [31:0] sw;
    logic [7:0]  ic;
    logic [7:0]  el;
    logic [31:0] pl;
    logic [31:0] word;
    logic        full;
    logic [3:0]  sel;
    logic [7:0]  expect_chr;
    logic [7:0]  ic_inc;
    logic [31:0] pl_dec;

    // restart wipes decode state before the byte is used as byte 0
    if (in_restart) begin
      ph = PH_HEADER;
      hc = '0;
      bc = '0;
      sw = '0;
      ic = '0;
      el = '0;
      pl = '0;
    end else begin
      ph = phase_r;
      hc = header_count_r;
      bc = bit_count_r;
      sw = shift_word_r;
      ic = item_count_r;
      el = ext_length_r;
      pl = payload_left_r;
    end

    res_vld    = 1'b0;
    res        = '0;
    word       = {sw[30:0], in_pixel_byte[0]};
    full       = 1'b0;
    sel        = 4'(magic_used - 4'd1 - ic[3:0]);
    expect_chr = magic_chars_r[{sel[2:0], 3'b000} +: 8];
    ic_inc     = ic + 8'd1;
    pl_dec     = pl - 32'd1;

    if (ph == PH_HEADER && hc < header_bytes_r) begin
      // still inside the file header: count and drop
      hc = hc + 8'd1;
    end else begin
      if (ph == PH_HEADER) begin
        ph = PH_MAGIC;
      end
      if (ph == PH_MAGIC && ic >= {4'd0, magic_used}) begin
        ph = PH_EXTLEN;
        ic = '0;
      end
      if (ph != PH_DONE && ph != PH_HALT) begin
        if (ph == PH_EXTLEN || ph == PH_PAYLEN) begin
          full = (bc == LAST_BIT_SIZE);
        end else begin
          full = (bc >= LAST_BIT_CHAR);
        end
        if (!full) begin
          bc = bc + 5'd1;
          sw = word;
        end else begin
          bc = '0;
          sw = '0;
          sel        = 4'(magic_used - 4'd1 - ic[3:0]);
          expect_chr = magic_chars_r[{sel[2:0], 3'b000} +: 8];
          ic_inc     = ic + 8'd1;
          unique case (ph)
            PH_MAGIC: begin
              if (word[7:0] != expect_chr) begin
                ph             = PH_HALT;
                res_vld        = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_MAGIC;
              end else begin
                ic = ic_inc;
                if (ic_inc >= {4'd0, magic_used}) begin
                  ph = PH_EXTLEN;
                  ic = '0;
                end
              end
            end
            PH_EXTLEN: begin
              res_vld = 1'b1;
              if (word >= {24'd0, extension_limit_r}) begin
                ph             = PH_HALT;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_EXT_LEN;
              end else begin
                el        = word[7:0];
                ic        = '0;
                ph        = (word[7:0] == 8'd0) ? PH_PAYLEN : PH_EXTCHR;
                res.kind  = KIND_EXTLEN;
                res.value = word;
              end
            end
            PH_EXTCHR: begin
              ic = ic_inc;
              if (ic_inc >= el) begin
                ph = PH_PAYLEN;
              end
              res_vld   = 1'b1;
              res.kind  = KIND_EXTCHR;
              res.value = {24'd0, word[7:0]};
            end
            PH_PAYLEN: begin
              // negative or zero length: report it and stop
              if (!word[31] && word != 32'd0) begin
                pl = word;
                ph = PH_PAYLOAD;
              end else begin
                pl = '0;
                ph = PH_DONE;
              end
              res_vld   = 1'b1;
              res.kind  = KIND_PAYLEN;
              res.value = word;
            end
            PH_PAYLOAD: begin
              pl            = pl_dec;
              res_vld       = 1'b1;
              res.kind      = KIND_PAYBYTE;
              res.value     = {24'd0, word[7:0]};
              res.last_byte = (pl_dec == 32'd0);
              if (pl_dec == 32'd0) begin
                ph = PH_DONE;
              end
            end
            default: ;
          endcase
        end
      end
    end

    phase_nxt        = ph;
    header_count_nxt = hc;
    bit_count_nxt    = bc;
    shift_word_nxt   = sw;
    item_count_nxt   = ic;
    ext_length_nxt   = el;
    payload_left_nxt = pl;
  end

  // Advance decode state on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_count_r <= '0;
      bit_count_r    <= '0;
      shift_word_r   <= '0;
      item_count_r   <= '0;
      ext_length_r   <= '0;
      payload_left_r <= '0;
    end else if (in_acc) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      bit_count_r    <= bit_count_nxt;
      shift_word_r   <= shift_word_nxt;
      item_count_r   <= item_count_nxt;
      ext_length_r   <= ext_length_nxt;
      payload_left_r <= payload_left_nxt;
    end
  end

  // Load a new result beat, or drop the held one once the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_value      = out_r.value;
  assign out_last_byte  = out_r.last_byte;
  assign out_error_code = out_r.error_code;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An error beat always leaves the decoder halted.
  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_vld && res.kind == KIND_ERROR) |=> (phase_r == PH_HALT))
    else $error("error beat did not halt decoding");

  // The final payload byte always ends the image.
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_vld && res.last_byte) |=> (phase_r == PH_DONE))
    else $error("last payload byte did not end decoding");

  // While skipping the header no hidden bits have been gathered.
  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (bit_count_r == 5'd0 && shift_word_r == 32'd0))
    else $error("bits gathered during header skip");

  // The last-byte flag only rides on payload bytes.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte) |-> (out_kind == KIND_PAYBYTE))
    else $error("last_byte set on a non-payload beat");

endmodule

// ===== sim/lsb_stego_payload_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_stego_payload_decoder_test: self-checking bench for the stego decoder
// Builds stego byte streams: header filler, magic chars, extension and payload
// fields hidden in the pixel LSBs. Some are well formed, some broken and some
// noise. A scoreboard predicts every result beat and checks what comes out.
// Both channels idle and stall at random, and one long sink hold-off backs
// up the input.
// ----------------------------------------------------------------------------
module lsb_stego_payload_decoder_test;
  import lspd_pkg::*;

  localparam int     CLK_HALF     = 6;
  localparam int     RANDOM_BEATS = 100;
  localparam int     HOLD_CYCLES  = 150;
  localparam int     DRAIN_CYCLES = 8;
  localparam longint RUN_LIMIT_NS = 20_000_000;

  // Upper seven bits of a pixel byte: random, or forced to an extreme
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       rst;
  } beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a cycle-free copy of the decode state machine. It predicts the
  // result beats and checks them in order.
  // --------------------------------------------------------------------------
  class decode_scoreboard;
    logic [63:0] magic_chars;
    logic [3:0]  magic_count;
    logic [7:0]  header_bytes;
    logic [7:0]  ext_limit;

    phase_t      phase;
    logic [7:0]  header_count;
    logic [4:0]  bit_count;
    logic [31:0] shift_word;
    logic [7:0]  item_count;
    logic [7:0]  ext_length;
    logic [31:0] payload_left;

    result_t     pending_q[$];
    int          errors;

    function new();
      magic_chars  = MAGIC_CHARS_RST;
      magic_count  = MAGIC_COUNT_RST;
      header_bytes = HEADER_BYTES_RST;
      ext_limit    = EXTENSION_LIMIT_RST;
      errors       = 0;
      restart_decode();
    endfunction

    function void restart_decode();
      phase        = PH_HEADER;
      header_count = '0;
      bit_count    = '0;
      shift_word   = '0;
      item_count   = '0;
      ext_length   = '0;
      payload_left = '0;
    endfunction

    // Counts above eight check eight chars
    function int magic_used();
      return (magic_count > MAGIC_MAX) ? int'(MAGIC_MAX) : int'(magic_count);
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] d);
      case (idx)
        REG_MAGIC_CHARS:     magic_chars  = d;
        REG_MAGIC_COUNT:     magic_count  = d[3:0];
        REG_HEADER_BYTES:    header_bytes = d[7:0];
        REG_EXTENSION_LIMIT: ext_limit    = d[7:0];
        default: ;
      endcase
    endfunction

    function void push_result(logic [2:0] kind, logic [31:0] value, logic last,
                              logic code);
      result_t r;
      r.kind       = kind;
      r.value      = value;
      r.last_byte  = last;
      r.error_code = code;
      pending_q.push_back(r);
    endfunction

    // Advance the decoder by one accepted input beat
    function void note_beat(logic [7:0] pix, logic restart);
      int          need;
      int          sh;
      logic [31:0] word;
      logic [7:0]  want;
      if (restart) restart_decode();
      if (phase == PH_HEADER) begin
        if (header_count < header_bytes) begin
          header_count++;
          return;
        end
        phase = PH_MAGIC;
      end
      if (phase == PH_MAGIC && int'(item_count) >= magic_used()) begin
        phase      = PH_EXTLEN;
        item_count = '0;
      end
      if (phase == PH_DONE || phase == PH_HALT) return;

      need       = (phase == PH_EXTLEN || phase == PH_PAYLEN) ? 32 : 8;
      shift_word = {shift_word[30:0], pix[0]};
      if (int'(bit_count) + 1 < need) begin
        bit_count++;
        return;
      end
      bit_count  = '0;
      word       = shift_word;
      shift_word = '0;

      case (phase)
        PH_MAGIC: begin
          sh   = 8 * (magic_used() - 1 - int'(item_count));
          want = 8'(magic_chars >> sh);
          if (word[7:0] != want) begin
            phase = PH_HALT;
            push_result(KIND_ERROR, '0, 1'b0, ERR_MAGIC);
          end else begin
            item_count++;
            if (int'(item_count) >= magic_used()) begin
              phase      = PH_EXTLEN;
              item_count = '0;
            end
          end
        end
        PH_EXTLEN: begin
          // unsigned compare: a negative length is too long as well
          if (word >= 32'(ext_limit)) begin
            phase = PH_HALT;
            push_result(KIND_ERROR, '0, 1'b0, ERR_EXT_LEN);
          end else begin
            ext_length = word[7:0];
            item_count = '0;
            if (ext_length == 8'd0) phase = PH_PAYLEN;
            else phase = PH_EXTCHR;
            push_result(KIND_EXTLEN, word, 1'b0, 1'b0);
          end
        end
        PH_EXTCHR: begin
          item_count++;
          if (item_count >= ext_length) phase = PH_PAYLEN;
          push_result(KIND_EXTCHR, {24'd0, word[7:0]}, 1'b0, 1'b0);
        end
        PH_PAYLEN: begin
          if (!word[31] && word != 32'd0) begin
            payload_left = word;
            phase        = PH_PAYLOAD;
          end else begin
            payload_left = '0;
            phase        = PH_DONE;
          end
          push_result(KIND_PAYLEN, word, 1'b0, 1'b0);
        end
        default: begin
          payload_left--;
          if (payload_left == 32'd0) begin
            phase = PH_DONE;
            push_result(KIND_PAYBYTE, {24'd0, word[7:0]}, 1'b1, 1'b0);
          end else begin
            push_result(KIND_PAYBYTE, {24'd0, word[7:0]}, 1'b0, 1'b0);
          end
        end
      endcase
    endfunction

    // Compare one accepted result beat with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result: kind %0d value %0h", got.kind, got.value);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %0h, got %0h", want.value, got.value);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %0d, got %0d", want.last_byte, got.last_byte);
        errors++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_pixel_byte;
  logic        in_restart;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [31:0] out_value;
  logic        out_last_byte;
  logic        out_error_code;

  lsb_stego_payload_decoder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_byte  (in_pixel_byte),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_last_byte  (out_last_byte),
    .out_error_code (out_error_code)
  );

  decode_scoreboard sb;

  // Stream under construction; the restart flag sticks to the next beat pushed
  beat_t   beat_q[$];
  logic    pending_restart;
  fill_t   fill_mode;
  bit      no_gaps;
  bit      hold_off_req;
  int      calm_left;
  int      beats_sent;
  result_t seen_result;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: sample at the rising edge, stall at the falling edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result.kind       = out_kind;
      seen_result.value      = out_value;
      seen_result.last_byte  = out_last_byte;
      seen_result.error_code = out_error_code;
      sb.check_result(seen_result);
    end
  end

  // Alternate free-running stretches with short and long stalls. On request,
  // hold off for a long stretch so that the result register fills and the
  // block has to stall its input.
  initial begin : sink
    int   run_left;
    int   r;
    logic run_stall;
    out_stall = 1'b0;
    run_left  = 0;
    run_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall    = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            run_stall = 1'b0;
            run_left  = $urandom_range(1, 40);
          end else if (r < 90) begin
            run_stall = 1'b1;
            run_left  = $urandom_range(1, 3);
          end else begin
            run_stall = 1'b1;
            run_left  = $urandom_range(8, 40);
          end
        end
        run_left--;
        out_stall = run_stall;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Mostly back-to-back beats, some short gaps, a few long ones, and now and
  // then a calm stretch with no gaps at all
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  // Offer one beat, hold it until accepted, then idle for a random gap
  task automatic send_beat(beat_t b);
    int gap;
    @(negedge clk);
    in_valid      = 1'b1;
    in_pixel_byte = b.pix;
    in_restart    = b.rst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(b.pix, b.rst);
    beats_sent++;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      // scramble the idle payload; the block must ignore it
      in_valid      = 1'b0;
      in_pixel_byte = 8'($urandom);
      in_restart    = 1'($urandom);
    end
  endtask

  task automatic play_beats();
    beat_t b;
    while (beat_q.size() > 0) begin
      b = beat_q.pop_front();
      send_beat(b);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Drain every predicted result, then give the block a few spare cycles
  task automatic wait_idle();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [63:0] d);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_config(logic [63:0] chars, logic [3:0] cnt, logic [7:0] hdr,
                            logic [7:0] lim);
    wait_idle();
    cfg_write(REG_MAGIC_CHARS, chars);
    cfg_write(REG_MAGIC_COUNT, 64'(cnt));
    cfg_write(REG_HEADER_BYTES, 64'(hdr));
    cfg_write(REG_EXTENSION_LIMIT, 64'(lim));
  endtask

  // --------------------------------------------------------------------------
  // Stream builders: hide bits MSB first in the pixel LSBs
  // --------------------------------------------------------------------------
  task automatic push_beat(logic lsb);
    beat_t b;
    b.pix = 8'($urandom);
    case (fill_mode)
      FILL_ONES:  b.pix[7:1] = '1;
      FILL_ZEROS: b.pix[7:1] = '0;
      default: ;
    endcase
    b.pix[0]        = lsb;
    b.rst           = pending_restart;
    pending_restart = 1'b0;
    beat_q.push_back(b);
  endtask

  task automatic push_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) push_beat(v[i]);
  endtask

  task automatic push_noise(int n);
    repeat (n) push_beat(1'($urandom));
  endtask

  // Restart marker plus header filler for the current header size
  task automatic start_image();
    pending_restart = 1'b1;
    push_noise(int'(sb.header_bytes));
  endtask

  // Push n magic chars; corrupt one bit of char bad_pos (none if negative)
  task automatic push_magic(int n, int bad_pos);
    int         used;
    int         sh;
    logic [7:0] ch;
    used = sb.magic_used();
    for (int i = 0; i < n; i++) begin
      sh = 8 * (used - 1 - i);
      ch = (sh >= 0) ? 8'(sb.magic_chars >> sh) : 8'($urandom);
      if (i == bad_pos) ch ^= 8'(1 << $urandom_range(0, 7));
      push_bits({24'd0, ch}, 8);
    end
  endtask

  // Extension length and chars, payload length and bytes. An oversize
  // extension halts the block, so only filler follows it.
  task automatic push_body(logic [31:0] ext_len, logic [31:0] pay_len);
    push_bits(ext_len, 32);
    if (ext_len >= 32'(sb.ext_limit)) begin
      push_noise($urandom_range(0, 4));
      return;
    end
    repeat (int'(ext_len)) push_bits($urandom, 8);
    push_bits(pay_len, 32);
    if (!pay_len[31]) repeat (int'(pay_len)) push_bits($urandom, 8);
  endtask

  task automatic random_config();
    int         r;
    logic [7:0] hdr;
    logic [7:0] lim;
    logic [3:0] cnt;
    // keep headers short mostly so the run stays busy with hidden data
    r   = $urandom_range(0, 19);
    hdr = (r < 14) ? 8'($urandom_range(0, 6)) :
          (r < 18) ? 8'($urandom_range(7, 40)) :
          (r == 18) ? 8'd0 : 8'd255;
    cnt = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 4)) :
                                       4'($urandom_range(5, 15));
    r   = $urandom_range(0, 19);
    lim = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'd255 :
          8'($urandom_range(2, 12));
    set_config({$urandom, $urandom}, cnt, hdr, lim);
  endtask

  // One image: mostly well formed with random content; some carry a bad
  // magic char, an oversize or negative field, a stray restart, or get cut
  task automatic random_image();
    int          used;
    int          bad;
    int          r;
    int          keep;
    logic [31:0] ext_len;
    logic [31:0] pay_len;
    logic [7:0]  lim;
    used = sb.magic_used();
    lim  = sb.ext_limit;
    bad  = ($urandom_range(0, 9) == 0 && used > 0) ? $urandom_range(0, used - 1) : -1;

    if (lim == 8'd0) begin
      ext_len = $urandom_range(0, 3);
    end else begin
      r = $urandom_range(0, 9);
      if (r < 7) ext_len = $urandom_range(0, (int'(lim) - 1 < 5) ? int'(lim) - 1 : 5);
      else if (r == 7) ext_len = 32'(lim) + $urandom_range(0, 3);
      else if (r == 8) ext_len = $urandom;
      else ext_len = 32'd0;
    end

    r = $urandom_range(0, 9);
    if (r < 6) pay_len = $urandom_range(1, 8);
    else if (r < 8) pay_len = 32'd0;
    else if (r == 8) pay_len = {1'b1, 31'($urandom)};
    else pay_len = $urandom_range(9, 24);

    start_image();
    push_magic(used, bad);
    push_body(ext_len, pay_len);
    if ($urandom_range(0, 7) == 0) pending_restart = 1'b1;
    push_noise($urandom_range(0, 4));
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, beat_q.size());
      while (beat_q.size() > keep) void'(beat_q.pop_back());
    end
    play_beats();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int random_start;
    sb              = new();
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_pixel_byte   = '0;
    in_restart      = 1'b0;
    pending_restart = 1'b0;
    fill_mode       = FILL_RANDOM;
    no_gaps         = 1'b0;
    hold_off_req    = 1'b0;
    calm_left       = 0;
    beats_sent      = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset registers: full header, two magic chars, upper pixel bits all ones
    fill_mode = FILL_ONES;
    start_image();
    push_magic(2, -1);
    push_body(32'd3, 32'd4);
    play_beats();

    // Magic mismatch on the second char halts; later bytes give nothing
    fill_mode = FILL_ZEROS;
    start_image();
    push_magic(2, 1);
    push_noise(6);
    play_beats();
    fill_mode = FILL_RANDOM;

    // Zero header, no magic, zero extension length
    set_config({$urandom, $urandom}, 4'd0, 8'd0, 8'd255);
    start_image();
    push_body(32'd0, 32'd2);
    push_noise(3);
    play_beats();

    // Extension length equal to the top limit is too long
    start_image();
    push_body(32'd255, 32'd1);
    play_beats();

    // A zero limit rejects even a zero length
    wait_idle();
    cfg_write(REG_EXTENSION_LIMIT, 64'd0);
    start_image();
    push_body(32'd0, 32'd1);
    play_beats();

    // Magic count above eight checks eight; negative extension length errors
    set_config({$urandom, $urandom}, 4'd12, 8'd3, 8'd8);
    start_image();
    push_magic(8, -1);
    push_body(32'hFFFF_FFF0, 32'd0);
    play_beats();

    // Zero payload length, then negative payload length: no payload follows
    start_image();
    push_magic(8, -1);
    push_body(32'd1, 32'd0);
    push_noise(8);
    play_beats();
    start_image();
    push_magic(8, -1);
    push_body(32'd2, 32'h8000_0001);
    push_noise(8);
    play_beats();

    // Shrink header and magic count while the decoder sits mid-image
    set_config({$urandom, $urandom}, 4'd3, 8'd200, 8'd8);
    pending_restart = 1'b1;
    push_noise(20);
    play_beats();
    wait_idle();
    cfg_write(REG_HEADER_BYTES, 64'd5);
    push_magic(2, -1);
    play_beats();
    wait_idle();
    cfg_write(REG_MAGIC_COUNT, 64'd2);
    push_body(32'd1, 32'd3);
    play_beats();

    // Restart in the middle of a payload
    set_config({$urandom, $urandom}, 4'd1, 8'd2, 8'd8);
    start_image();
    push_magic(1, -1);
    push_body(32'd1, 32'd6);
    repeat (20) void'(beat_q.pop_back());
    start_image();
    push_magic(1, -1);
    push_body(32'd0, 32'd1);
    play_beats();

    // Back-to-back beats against a long sink hold-off: fill up, stall input
    set_config({$urandom, $urandom}, 4'd0, 8'd0, 8'd8);
    no_gaps      = 1'b1;
    hold_off_req = 1'b1;
    start_image();
    push_body(32'd5, 32'd24);
    play_beats();
    no_gaps = 1'b0;

    // Random phases: maybe a new register setting, then a few images
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      if ($urandom_range(0, 1) == 0) random_config();
      repeat ($urandom_range(1, 3)) random_image();
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
